### hw/rtl/quadcopter_attitude_pd_mixer_top_assert.svh
// ----------------------------------------------------------------------------
// quadcopter_attitude_pd_mixer_top_assert.svh
// Assertion macros used by the checker file of the attitude mixer.
// Both macros expect signals named clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef QUADCOPTER_ATTITUDE_PD_MIXER_TOP_ASSERT_SVH
`define QUADCOPTER_ATTITUDE_PD_MIXER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define QAPM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define QAPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/qapm_pkg.sv
// ----------------------------------------------------------------------------
// qapm_pkg
// Shared constants, types and the thrust table of the attitude PD mixer.
// ----------------------------------------------------------------------------
package qapm_pkg;

    // Fixed point: angles and rates carry this many fraction bits
    localparam int ANGLE_FRAC_BITS = 6;

    // Field widths
    localparam int ANGLE_W   = 15;
    localparam int RATE_W    = 18;
    localparam int STICK_W   = 9;
    localparam int GAIN_W    = 8;
    localparam int MOTOR_W   = 13;
    localparam int MODE_W    = 2;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_CNT  = 6;

    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 56;

    // Motor speeds and term limits
    localparam int IDLE_SPEED = 2400;
    localparam int LOW_SPEED  = IDLE_SPEED + 150;
    localparam int TOP_SPEED  = 5200;
    localparam int PR_LIMIT   = (TOP_SPEED - LOW_SPEED) * 3 / 10;
    localparam int YAW_LIMIT  = (TOP_SPEED - LOW_SPEED) * 2 / 10;

    // Stick thresholds and blink period
    localparam int STICK_LOW    = -((498 - 249) / 2);
    localparam int YAW_DEADBAND = 5;
    localparam int BLINK_PERIOD = 40;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ARMED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLYING = 2'd2;

    // Gain register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_D = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_P  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_P   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_D   = 3'd5;
    localparam int P_GAIN_RST = 48;
    localparam int D_GAIN_RST = 16;

    // Error is tilt in 1/8 of an angle unit minus the stick in degrees
    localparam int STICK_ERR_SH = 3;
    localparam int ERR_W = ((17 > 8 + ANGLE_FRAC_BITS) ? 17 : 8 + ANGLE_FRAC_BITS) + 2;
    localparam int CRASH_LIM = (90 << STICK_ERR_SH) << ANGLE_FRAC_BITS;

    // Shared multiplier
    localparam int MUL_A_W = (ERR_W > RATE_W) ? ERR_W : RATE_W;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int TERM_W  = 12;
    localparam int MIX_W   = 15;

    // Rounding shifts: P over 2^F*128, D over 2^F*16
    localparam int P_SH   = ANGLE_FRAC_BITS + 7;
    localparam int D_SH   = ANGLE_FRAC_BITS + 4;
    localparam int P_HALF = 1 << (P_SH - 1);
    localparam int D_HALF = 1 << (D_SH - 1);

    // Yaw stick term: nearest of n/80 as floor((n+40)/16) then floor(./5)
    localparam int YAW_STICK_DIV = 80;
    localparam int STICK_ROUND   = YAW_STICK_DIV / 2;
    localparam int STICK_PRE_SH  = 4;
    localparam int RECIP_DIV     = YAW_STICK_DIV >> STICK_PRE_SH;
    localparam int RECIP_SH      = 18;
    localparam int RECIP_MUL     = ((1 << RECIP_SH) + RECIP_DIV - 1) / RECIP_DIV;
    localparam int RECIP_BIAS    = 5000;
    localparam int RECIP_OFFS    = RECIP_BIAS / RECIP_DIV;
    localparam int RECIP_W       = 14;

    // Thrust table: round(89.44 * sqrt(t)), t = 0..255
    localparam int ROOT_W    = 11;
    localparam int THR_IDX_W = STICK_W - 1;
    localparam int THR_CNT   = 1 << THR_IDX_W;

    function automatic logic [THR_CNT-1:0][ROOT_W-1:0] build_thrust_tab();
        logic [THR_CNT-1:0][ROOT_W-1:0] tab;
        longint lim;
        longint lo;
        longint hi;
        longint mid;
        for (int t = 0; t < THR_CNT; t++)
        begin
            // count odd k with k*k*10000 <= 4*79995136*t
            lim = (longint'(4) * 79995136 * t) / 10000;
            lo  = 0;
            hi  = 4095;
            for (int k = 0; k < 13; k++)
            begin
                mid = (lo + hi + 1) >> 1;
                if (mid * mid <= lim)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            tab[t] = ROOT_W'((lo + 1) >> 1);
        end
        return tab;
    endfunction

    localparam logic [THR_CNT-1:0][ROOT_W-1:0] THRUST_TAB = build_thrust_tab();

    // Term sequence of one flying tick
    typedef enum logic [2:0] {
        OP_PITCH_P,
        OP_PITCH_D,
        OP_ROLL_P,
        OP_ROLL_D,
        OP_YAW_P,
        OP_YAW_RECIP,
        OP_YAW_D
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic              load;
        logic              mul_en;
        logic              post_en;
        op_t               op;
        logic              out_load;
        logic [MODE_W-1:0] motor_mode;
        logic [MODE_W-1:0] mode_next;
        logic              led_next;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic thr_pos;
        logic thr_low;
        logic arm_ok;
        logic crash;
        logic yaw_cmd;
    } dp_status_t;

endpackage

### hw/rtl/qapm_ctrl.sv
// ----------------------------------------------------------------------------
// qapm_ctrl
// Tick sequencer and flight mode machine: steps the datapath through the
// PD terms, owns the arming mode, the blink counter and the output valid.
// ----------------------------------------------------------------------------
module qapm_ctrl
    import qapm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_POST,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [CNT_W-1:0]  blink_reg, blink_next;
    logic              led_reg, led_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [MODE_W-1:0] mode_new;
    logic [CNT_W-1:0]  blink_new;
    logic              led_new;
    logic              finish;

    // Mode, blink and LED outcome of the current tick
    always_comb
    begin
        mode_new  = MODE_IDLE;
        blink_new = blink_reg;
        led_new   = led_reg;
        unique case (mode_reg)
            MODE_ARMED:
            begin
                mode_new = status.thr_pos ? MODE_FLYING : MODE_ARMED;
            end
            MODE_FLYING:
            begin
                mode_new = (status.thr_low || status.crash) ? MODE_IDLE : MODE_FLYING;
                if (blink_reg == CNT_W'(BLINK_PERIOD))
                    led_new = !led_reg;
                blink_new = ((blink_reg >= CNT_W'(BLINK_PERIOD)) ? '0 : blink_reg)
                          + CNT_W'(1);
            end
            default:
            begin
                // idle, and the unused code acts as idle
                mode_new = status.arm_ok ? MODE_ARMED : MODE_IDLE;
            end
        endcase
    end

    assign finish = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = OP_PITCH_P;
                    state_next = (mode_reg == MODE_FLYING) ? S_MUL : S_FINISH;
                end
            end
            S_MUL:
            begin
                state_next = S_POST;
            end
            S_POST:
            begin
                state_next = S_MUL;
                case (op_reg)
                    OP_PITCH_P:   op_next = OP_PITCH_D;
                    OP_PITCH_D:   op_next = OP_ROLL_P;
                    OP_ROLL_P:    op_next = OP_ROLL_D;
                    OP_ROLL_D:    op_next = OP_YAW_P;
                    OP_YAW_P:     op_next = status.yaw_cmd ? OP_YAW_RECIP : OP_YAW_D;
                    OP_YAW_RECIP: op_next = OP_YAW_D;
                    default:      state_next = S_FINISH;
                endcase
            end
            S_FINISH:
            begin
                if (finish)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commit of the tick and output valid
    always_comb
    begin
        mode_next  = finish ? mode_new : mode_reg;
        blink_next = finish ? blink_new : blink_reg;
        led_next   = finish ? led_new : led_reg;
        if (finish)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_PITCH_P;
            mode_reg     <= MODE_IDLE;
            blink_reg    <= '0;
            led_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            mode_reg     <= mode_next;
            blink_reg    <= blink_next;
            led_reg      <= led_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Outputs
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd.load       = s_tvalid && (state_reg == S_IDLE);
        cmd.mul_en     = (state_reg == S_MUL);
        cmd.post_en    = (state_reg == S_POST);
        cmd.op         = op_reg;
        cmd.out_load   = finish;
        cmd.motor_mode = mode_reg;
        cmd.mode_next  = mode_new;
        cmd.led_next   = led_new;
    end

endmodule

### hw/rtl/qapm_datapath.sv
// ----------------------------------------------------------------------------
// qapm_datapath
// Gain registers, input capture, shared multiplier with rounding and
// clamping of the PD terms, X mixer and the output register.
// ----------------------------------------------------------------------------
module qapm_datapath
    import qapm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [GAIN_W-1:0]      cfg_data,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // Input field offsets
    localparam int TX_LSB  = 0;
    localparam int TY_LSB  = TX_LSB + ANGLE_W;
    localparam int HZ_LSB  = TY_LSB + ANGLE_W;
    localparam int RX_LSB  = HZ_LSB + ANGLE_W;
    localparam int RY_LSB  = RX_LSB + RATE_W;
    localparam int RZ_LSB  = RY_LSB + RATE_W;
    localparam int THR_LSB = RZ_LSB + RATE_W;
    localparam int SP_LSB  = THR_LSB + STICK_W;
    localparam int SR_LSB  = SP_LSB + STICK_W;
    localparam int SY_LSB  = SR_LSB + STICK_W;

    // Gains
    logic [GAIN_W-1:0] gain_reg [GAIN_CNT];

    // Captured tick
    logic signed [ERR_W-1:0]   ex_reg, ey_reg;
    logic signed [ANGLE_W-1:0] hz_reg;
    logic signed [RATE_W-1:0]  rx_reg, ry_reg, rz_reg;
    logic signed [STICK_W:0]   sy_neg_reg;
    logic [MOTOR_W-1:0]        base_reg;
    dp_status_t                status_reg;

    // Term pipeline
    logic signed [PROD_W-1:0]  prod_reg;
    logic [RECIP_W-1:0]        recip_reg;
    logic signed [TERM_W-1:0]  p_acc_reg, r_acc_reg, y_acc_reg;
    logic [OUT_TDATA_W-1:0]    out_reg;

    // Input unpack
    logic signed [ANGLE_W-1:0] tx, ty, hz;
    logic signed [RATE_W-1:0]  rx, ry, rz;
    logic signed [STICK_W-1:0] thr, sp, sr, sy;
    logic [THR_IDX_W-1:0]      thr_idx;
    logic signed [ERR_W-1:0]   ex_next, ey_next;
    logic [MOTOR_W-1:0]        base_next;
    dp_status_t                status_next;

    assign tx  = s_tdata[TX_LSB +: ANGLE_W];
    assign ty  = s_tdata[TY_LSB +: ANGLE_W];
    assign hz  = s_tdata[HZ_LSB +: ANGLE_W];
    assign rx  = s_tdata[RX_LSB +: RATE_W];
    assign ry  = s_tdata[RY_LSB +: RATE_W];
    assign rz  = s_tdata[RZ_LSB +: RATE_W];
    assign thr = s_tdata[THR_LSB +: STICK_W];
    assign sp  = s_tdata[SP_LSB +: STICK_W];
    assign sr  = s_tdata[SR_LSB +: STICK_W];
    assign sy  = s_tdata[SY_LSB +: STICK_W];

    // Angle errors, thrust base and tick flags at capture
    assign ey_next = (ERR_W'(ty) <<< STICK_ERR_SH) - (ERR_W'(sp) <<< ANGLE_FRAC_BITS);
    assign ex_next = (ERR_W'(tx) <<< STICK_ERR_SH) - (ERR_W'(sr) <<< ANGLE_FRAC_BITS);
    assign thr_idx = thr[STICK_W-1] ? '0 : thr[THR_IDX_W-1:0];
    assign base_next = MOTOR_W'(LOW_SPEED) + MOTOR_W'(THRUST_TAB[thr_idx]);

    always_comb
    begin
        status_next.thr_pos = (thr > 0);
        status_next.thr_low = (thr <= STICK_LOW);
        status_next.arm_ok  = (thr <= STICK_LOW) && (sy <= STICK_LOW)
                           && (sp <= STICK_LOW) && (sr >= STICK_LOW);
        status_next.crash   = (ex_next < -CRASH_LIM) || (ex_next > CRASH_LIM)
                           || (ey_next < -CRASH_LIM) || (ey_next > CRASH_LIM);
        status_next.yaw_cmd = (sy < -YAW_DEADBAND) || (sy > YAW_DEADBAND);
    end

    // Gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[REG_PITCH_P] <= GAIN_W'(P_GAIN_RST);
            gain_reg[REG_PITCH_D] <= GAIN_W'(D_GAIN_RST);
            gain_reg[REG_ROLL_P]  <= GAIN_W'(P_GAIN_RST);
            gain_reg[REG_ROLL_D]  <= GAIN_W'(D_GAIN_RST);
            gain_reg[REG_YAW_P]   <= GAIN_W'(P_GAIN_RST);
            gain_reg[REG_YAW_D]   <= GAIN_W'(D_GAIN_RST);
        end
        else if (cfg_we && (cfg_index <= REG_YAW_D))
        begin
            gain_reg[cfg_index] <= cfg_data;
        end
    end

    // Multiplier operand select
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    always_comb
    begin
        case (cmd.op)
            OP_PITCH_P:
            begin
                mul_a = MUL_A_W'(ey_reg);
                mul_b = MUL_B_W'(gain_reg[REG_PITCH_P]);
            end
            OP_PITCH_D:
            begin
                mul_a = MUL_A_W'(rx_reg);
                mul_b = MUL_B_W'(gain_reg[REG_PITCH_D]);
            end
            OP_ROLL_P:
            begin
                mul_a = MUL_A_W'(ex_reg);
                mul_b = MUL_B_W'(gain_reg[REG_ROLL_P]);
            end
            OP_ROLL_D:
            begin
                mul_a = MUL_A_W'(ry_reg);
                mul_b = MUL_B_W'(gain_reg[REG_ROLL_D]);
            end
            OP_YAW_P:
            begin
                // stick command overrides heading hold
                mul_a = status_reg.yaw_cmd ? MUL_A_W'(sy_neg_reg) : MUL_A_W'(hz_reg);
                mul_b = MUL_B_W'(gain_reg[REG_YAW_P]);
            end
            OP_YAW_RECIP:
            begin
                mul_a = MUL_A_W'(recip_reg);
                mul_b = MUL_B_W'(RECIP_MUL);
            end
            default:
            begin
                mul_a = MUL_A_W'(rz_reg);
                mul_b = MUL_B_W'(gain_reg[REG_YAW_D]);
            end
        endcase
    end

    // Rounding of the product
    logic signed [PROD_W-1:0] p_rnd, d_rnd, stick_pre, recip_q, term_raw;
    logic [RECIP_W-1:0]       recip_next;
    logic signed [TERM_W-1:0] term;
    logic                     yaw_term;

    assign p_rnd      = (prod_reg + PROD_W'(P_HALF)) >>> P_SH;
    assign d_rnd      = (prod_reg + PROD_W'(D_HALF)) >>> D_SH;
    assign stick_pre  = (prod_reg + PROD_W'(STICK_ROUND)) >>> STICK_PRE_SH;
    assign recip_next = RECIP_W'(stick_pre + PROD_W'(RECIP_BIAS));
    assign recip_q    = (prod_reg >>> RECIP_SH) - PROD_W'(RECIP_OFFS);

    always_comb
    begin
        case (cmd.op)
            OP_PITCH_P, OP_ROLL_P: term_raw = p_rnd;
            OP_YAW_RECIP:          term_raw = recip_q;
            default:               term_raw = d_rnd;
        endcase
    end

    assign yaw_term = (cmd.op == OP_YAW_P) || (cmd.op == OP_YAW_RECIP)
                   || (cmd.op == OP_YAW_D);

    // Clamp to the axis limit
    always_comb
    begin
        if (yaw_term)
        begin
            if (term_raw < -YAW_LIMIT)
                term = TERM_W'(-YAW_LIMIT);
            else if (term_raw > YAW_LIMIT)
                term = TERM_W'(YAW_LIMIT);
            else
                term = TERM_W'(term_raw);
        end
        else
        begin
            if (term_raw < -PR_LIMIT)
                term = TERM_W'(-PR_LIMIT);
            else if (term_raw > PR_LIMIT)
                term = TERM_W'(PR_LIMIT);
            else
                term = TERM_W'(term_raw);
        end
    end

    // X mixer
    logic signed [MIX_W-1:0]   base_s, p_s, r_s, y_s;
    logic signed [MIX_W-1:0]   mix [4];
    logic [MOTOR_W-1:0]        motor [4];

    assign base_s = MIX_W'(base_reg);
    assign p_s    = MIX_W'(p_acc_reg);
    assign r_s    = MIX_W'(r_acc_reg);
    assign y_s    = MIX_W'(y_acc_reg);

    assign mix[0] = base_s + p_s - r_s + y_s;
    assign mix[1] = base_s + p_s + r_s - y_s;
    assign mix[2] = base_s - p_s + r_s + y_s;
    assign mix[3] = base_s - p_s - r_s - y_s;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            case (cmd.motor_mode)
                MODE_FLYING:
                begin
                    if (mix[i] < LOW_SPEED)
                        motor[i] = MOTOR_W'(LOW_SPEED);
                    else if (mix[i] > TOP_SPEED)
                        motor[i] = MOTOR_W'(TOP_SPEED);
                    else
                        motor[i] = MOTOR_W'(mix[i]);
                end
                MODE_ARMED: motor[i] = MOTOR_W'(LOW_SPEED);
                default:    motor[i] = MOTOR_W'(IDLE_SPEED);
            endcase
        end
    end

    // Capture, term accumulation and output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ex_reg     <= ex_next;
            ey_reg     <= ey_next;
            hz_reg     <= hz;
            rx_reg     <= rx;
            ry_reg     <= ry;
            rz_reg     <= rz;
            sy_neg_reg <= -((STICK_W + 1)'(sy));
            base_reg   <= base_next;
            status_reg <= status_next;
            p_acc_reg  <= '0;
            r_acc_reg  <= '0;
            y_acc_reg  <= '0;
        end

        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;

        if (cmd.post_en)
        begin
            case (cmd.op)
                OP_PITCH_P, OP_PITCH_D: p_acc_reg <= p_acc_reg + term;
                OP_ROLL_P, OP_ROLL_D:   r_acc_reg <= r_acc_reg + term;
                OP_YAW_P:
                begin
                    if (status_reg.yaw_cmd)
                        recip_reg <= recip_next;
                    else
                        y_acc_reg <= y_acc_reg + term;
                end
                default:                y_acc_reg <= y_acc_reg + term;
            endcase
        end

        if (cmd.out_load)
            out_reg <= {status_reg.yaw_cmd, cmd.led_next, cmd.mode_next,
                        motor[3], motor[2], motor[1], motor[0]};
    end

    assign status  = status_reg;
    assign m_tdata = out_reg;

endmodule

### hw/rtl/quadcopter_attitude_pd_mixer_top.sv
// ----------------------------------------------------------------------------
// quadcopter_attitude_pd_mixer_top
// PD attitude controller with arming modes and X motor mixer, one result
// per control tick.
// ----------------------------------------------------------------------------
// One input transfer is one control tick and gives one result transfer. In
// idle or armed mode a tick goes from accept straight to its finish state.
// In flying mode the PD terms run one after another through a single shared
// 19x17 multiplier, each term a multiply, then round, clamp and accumulate.
// Yaw uses heading hold; when the yaw stick is outside its deadband the
// stick term adds a reciprocal multiply for its division by 80. The result
// sits in an output register; the next tick is accepted while it waits, and
// its own result is written once the previous one has been taken. Gains are
// to be written through the cfg port only while no tick is in progress; the
// user must keep to this, the block itself does not enforce it. Indexes
// above five are ignored.
// ----------------------------------------------------------------------------
module quadcopter_attitude_pd_mixer_top
    import qapm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // gain register write
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [GAIN_W-1:0]      cfg_data,
    // tick input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tilt_x, tilt_y, heading, rate_x, rate_y, rate_z,
    // stick_throttle, stick_pitch, stick_roll, stick_yaw, one pad bit
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // motor_one, motor_two, motor_three, motor_four,
    // flight_mode, status_led, heading_zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer and mode machine
    qapm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and output register
    qapm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule

### hw/rtl/qapm_checker.sv
// ----------------------------------------------------------------------------
// qapm_checker
// Port level checks of the attitude mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "quadcopter_attitude_pd_mixer_top_assert.svh"

module qapm_checker
    import qapm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [MOTOR_W-1:0] motor_one, motor_two, motor_three, motor_four;
    logic [MODE_W-1:0]  flight_mode;

    assign motor_one   = m_tdata[0 +: MOTOR_W];
    assign motor_two   = m_tdata[MOTOR_W +: MOTOR_W];
    assign motor_three = m_tdata[2 * MOTOR_W +: MOTOR_W];
    assign motor_four  = m_tdata[3 * MOTOR_W +: MOTOR_W];
    assign flight_mode = m_tdata[4 * MOTOR_W +: MODE_W];

    // A stalled result holds
    `QAPM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Motors in range and mode code valid
    `QAPM_ASSERT_SAME(a_motor_range, m_tvalid, motor_one >= IDLE_SPEED && motor_one <= TOP_SPEED && motor_two >= IDLE_SPEED && motor_two <= TOP_SPEED && motor_three >= IDLE_SPEED && motor_three <= TOP_SPEED && motor_four >= IDLE_SPEED && motor_four <= TOP_SPEED && flight_mode <= MODE_FLYING, "motor or mode out of range")

    // An armed result drives all motors at one common speed, idle or low
    `QAPM_ASSERT_SAME(a_armed_const, m_tvalid && flight_mode == MODE_ARMED, motor_one == motor_two && motor_two == motor_three && motor_three == motor_four && (motor_one == IDLE_SPEED || motor_one == LOW_SPEED), "armed result with uneven motors")

    // A flying result never drops below the low speed
    `QAPM_ASSERT_SAME(a_flying_floor, m_tvalid && flight_mode == MODE_FLYING, motor_one >= LOW_SPEED && motor_two >= LOW_SPEED && motor_three >= LOW_SPEED && motor_four >= LOW_SPEED, "flying motor below low speed")

    // One tick in flight at a time
    `QAPM_ASSERT_NEXT(a_one_tick, s_tvalid && s_tready, !s_tready, "input taken while a tick is in progress")

endmodule

bind quadcopter_attitude_pd_mixer_top qapm_checker u_qapm_checker (.*);

### tb/sv/quadcopter_attitude_pd_mixer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadcopter_attitude_pd_mixer_top_tb
// Self-checking bench for the attitude PD mixer. A queue-fed driver sends
// control ticks (directed corner cases, then arming/flight sequences with
// random content and some noise) while a monitor predicts each tick's motor
// result and compares it with what the block returns. Gains are rewritten
// between phases while the block is idle. Both sides stall at random.
// ----------------------------------------------------------------------------
module quadcopter_attitude_pd_mixer_top_tb;
    import qapm_pkg::*;

    // spare register indexes, the block ignores writes to them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam int ANGLE_MAX = 11520;
    localparam int RATE_MAX  = 128000;
    localparam int STICK_MAX = 145;
    localparam int PHASE_ITEMS = 170;

    // input tick, last member in the lowest bits
    typedef struct packed {
        logic                       pad;
        logic signed [STICK_W-1:0]  stick_yaw;
        logic signed [STICK_W-1:0]  stick_roll;
        logic signed [STICK_W-1:0]  stick_pitch;
        logic signed [STICK_W-1:0]  stick_throttle;
        logic signed [RATE_W-1:0]   rate_z;
        logic signed [RATE_W-1:0]   rate_y;
        logic signed [RATE_W-1:0]   rate_x;
        logic signed [ANGLE_W-1:0]  heading;
        logic signed [ANGLE_W-1:0]  tilt_y;
        logic signed [ANGLE_W-1:0]  tilt_x;
    } tick_t;

    // result, last member in the lowest bits
    typedef struct packed {
        logic               heading_zero;
        logic               status_led;
        logic [MODE_W-1:0]  flight_mode;
        logic [MOTOR_W-1:0] motor_four;
        logic [MOTOR_W-1:0] motor_three;
        logic [MOTOR_W-1:0] motor_two;
        logic [MOTOR_W-1:0] motor_one;
    } motor_out_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [GAIN_W-1:0]      cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // tilt_x, tilt_y, heading, rate_x, rate_y, rate_z,
    // stick_throttle, stick_pitch, stick_roll, stick_yaw, pad bit
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // motor_one, motor_two, motor_three, motor_four,
    // flight_mode, status_led, heading_zero
    logic [OUT_TDATA_W-1:0] m_tdata;

    // stimulus and scoreboard
    tick_t      tick_q[$];
    motor_out_t motor_exp_q[$];
    int         ticks_queued = 0;
    int         ticks_taken = 0;
    int         err_cnt = 0;
    logic       s_fire = 1'b0;
    int         s_gap = 0;
    int         m_gap = 0;
    bit         calm = 1'b0;

    // predictor state
    logic [GAIN_W-1:0] gain_r[GAIN_CNT];
    logic [MODE_W-1:0] mode_r;
    logic [CNT_W-1:0]  blink_r;
    logic              led_r;

    quadcopter_attitude_pd_mixer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // arithmetic helpers
    // ------------------------------------------------------------------
    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // nearest of num/den, halves go up
    function automatic longint round_div(longint num, longint den);
        return floor_div(2 * num + den, 2 * den);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // round(89.44 * sqrt(t)) by counting odd squares
    function automatic longint thrust_root(longint t);
        longint lim;
        longint v;
        lim = 4 * longint'(79995136) * t;
        v = 0;
        while ((2 * v + 1) * (2 * v + 1) * 10000 <= lim)
            v++;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // motor result of one tick; advances the mode, blink and LED state
    // ------------------------------------------------------------------
    function automatic motor_out_t predict_tick(tick_t t);
        motor_out_t r;
        longint one;
        longint tx, ty, hz, rx, ry, rz, thr, sp, sr, sy;
        longint ex, ey, pp, pr, py, b;
        longint m[4];
        bit yaw_cmd;
        one = longint'(1) << ANGLE_FRAC_BITS;
        tx = t.tilt_x;  ty = t.tilt_y;  hz = t.heading;
        rx = t.rate_x;  ry = t.rate_y;  rz = t.rate_z;
        thr = t.stick_throttle;  sp = t.stick_pitch;
        sr = t.stick_roll;  sy = t.stick_yaw;
        yaw_cmd = (sy < -YAW_DEADBAND || sy > YAW_DEADBAND);
        // angle errors in 1/8 of an angle unit
        ey = ty * 8 - sp * one;
        ex = tx * 8 - sr * one;

        if (mode_r == MODE_ARMED)
        begin
            for (int i = 0; i < 4; i++)
                m[i] = LOW_SPEED;
            if (thr > 0)
                mode_r = MODE_FLYING;
        end
        else if (mode_r == MODE_FLYING)
        begin
            pp = clip(round_div(ey * gain_r[REG_PITCH_P], one * 128), -PR_LIMIT, PR_LIMIT)
               + clip(round_div(rx * gain_r[REG_PITCH_D], one * 16), -PR_LIMIT, PR_LIMIT);
            pr = clip(round_div(ex * gain_r[REG_ROLL_P], one * 128), -PR_LIMIT, PR_LIMIT)
               + clip(round_div(ry * gain_r[REG_ROLL_D], one * 16), -PR_LIMIT, PR_LIMIT);
            if (yaw_cmd)
                py = round_div(-sy * gain_r[REG_YAW_P], 80);
            else
                py = round_div(hz * gain_r[REG_YAW_P], one * 16);
            py = clip(py, -YAW_LIMIT, YAW_LIMIT)
               + clip(round_div(rz * gain_r[REG_YAW_D], one * 16), -YAW_LIMIT, YAW_LIMIT);
            b = LOW_SPEED + thrust_root(thr > 0 ? thr : 0);
            m[0] = b + pp - pr + py;
            m[1] = b + pp + pr - py;
            m[2] = b - pp + pr + py;
            m[3] = b - pp - pr - py;
            for (int i = 0; i < 4; i++)
                m[i] = clip(m[i], LOW_SPEED, TOP_SPEED);
            // landing and crash
            if (thr <= STICK_LOW)
                mode_r = MODE_IDLE;
            if (ex < -CRASH_LIM || ex > CRASH_LIM || ey < -CRASH_LIM || ey > CRASH_LIM)
                mode_r = MODE_IDLE;
            // LED blink
            if (blink_r == BLINK_PERIOD)
                led_r = ~led_r;
            if (blink_r >= BLINK_PERIOD)
                blink_r = '0;
            blink_r = blink_r + 1'b1;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                m[i] = IDLE_SPEED;
            mode_r = MODE_IDLE;
            if (thr <= STICK_LOW && sy <= STICK_LOW && sp <= STICK_LOW && sr >= STICK_LOW)
                mode_r = MODE_ARMED;
        end

        r.motor_one    = MOTOR_W'(m[0]);
        r.motor_two    = MOTOR_W'(m[1]);
        r.motor_three  = MOTOR_W'(m[2]);
        r.motor_four   = MOTOR_W'(m[3]);
        r.flight_mode  = mode_r;
        r.status_led   = led_r;
        r.heading_zero = yaw_cmd;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // tick builders
    // ------------------------------------------------------------------
    function automatic int pick(int lo, int hi);
        return int'($urandom_range(hi - lo)) + lo;
    endfunction

    function automatic tick_t mk(int tx, int ty, int hd, int rx, int ry, int rz,
                                 int thr, int sp, int sr, int sy);
        tick_t t;
        t.pad = 1'b0;
        t.tilt_x = ANGLE_W'(tx);
        t.tilt_y = ANGLE_W'(ty);
        t.heading = ANGLE_W'(hd);
        t.rate_x = RATE_W'(rx);
        t.rate_y = RATE_W'(ry);
        t.rate_z = RATE_W'(rz);
        t.stick_throttle = STICK_W'(thr);
        t.stick_pitch = STICK_W'(sp);
        t.stick_roll = STICK_W'(sr);
        t.stick_yaw = STICK_W'(sy);
        return t;
    endfunction

    // every field anywhere between its negative and positive test maximum
    function automatic tick_t noise_tick();
        return mk(pick(-ANGLE_MAX, ANGLE_MAX), pick(-ANGLE_MAX, ANGLE_MAX),
                  pick(-ANGLE_MAX, ANGLE_MAX), pick(-RATE_MAX, RATE_MAX),
                  pick(-RATE_MAX, RATE_MAX), pick(-RATE_MAX, RATE_MAX),
                  pick(-STICK_MAX, STICK_MAX), pick(-STICK_MAX, STICK_MAX),
                  pick(-STICK_MAX, STICK_MAX), pick(-STICK_MAX, STICK_MAX));
    endfunction

    // tilts kept well inside the crash limit, throttle chosen by caller
    function automatic tick_t fly_tick(int thr_lo, int thr_hi);
        int sy;
        sy = ($urandom_range(99) < 40) ? pick(-YAW_DEADBAND, YAW_DEADBAND)
                                       : pick(-STICK_MAX, STICK_MAX);
        return mk(pick(-4000, 4000), pick(-4000, 4000), pick(-ANGLE_MAX, ANGLE_MAX),
                  pick(-RATE_MAX, RATE_MAX), pick(-RATE_MAX, RATE_MAX),
                  pick(-RATE_MAX, RATE_MAX), pick(thr_lo, thr_hi),
                  pick(-STICK_MAX, STICK_MAX), pick(-STICK_MAX, STICK_MAX), sy);
    endfunction

    task automatic push_tick(tick_t t);
        tick_q.push_back(t);
        ticks_queued++;
    endtask

    // one arm / take-off / fly / land-or-crash sequence, returns its length
    task automatic flight_seq(output int len);
        tick_t t;
        int n;
        len = 0;
        if ($urandom_range(99) < 30)
        begin
            push_tick(noise_tick());
            len++;
        end
        // arming pattern
        t = noise_tick();
        t.stick_throttle = STICK_W'(pick(-STICK_MAX, STICK_LOW));
        t.stick_yaw = STICK_W'(pick(-STICK_MAX, STICK_LOW));
        t.stick_pitch = STICK_W'(pick(-STICK_MAX, STICK_LOW));
        t.stick_roll = STICK_W'(pick(STICK_LOW, STICK_MAX));
        push_tick(t);
        len++;
        // a few armed ticks holding throttle down, then take-off
        n = pick(0, 2);
        for (int i = 0; i < n; i++)
        begin
            t = noise_tick();
            t.stick_throttle = STICK_W'(pick(-STICK_MAX, 0));
            push_tick(t);
            len++;
        end
        t = noise_tick();
        t.stick_throttle = STICK_W'(pick(1, STICK_MAX));
        push_tick(t);
        len++;
        // flying body, now and then long enough to blink
        n = ($urandom_range(99) < 15) ? pick(40, 70) : pick(1, 20);
        for (int i = 0; i < n; i++)
        begin
            push_tick(fly_tick(STICK_LOW + 1, STICK_MAX));
            len++;
        end
        // exit: landing or crash on either axis
        t = fly_tick(STICK_LOW + 1, STICK_MAX);
        case ($urandom_range(2))
            0: t.stick_throttle = STICK_W'(pick(-STICK_MAX, STICK_LOW));
            1: t.tilt_x = ANGLE_W'(($urandom_range(1) ? 1 : -1) * pick(7000, ANGLE_MAX));
            default: t.tilt_y = ANGLE_W'(($urandom_range(1) ? 1 : -1) * pick(7000, ANGLE_MAX));
        endcase
        push_tick(t);
        len++;
    endtask

    // ------------------------------------------------------------------
    // gain writes, only while nothing is in flight
    // ------------------------------------------------------------------
    task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx < GAIN_CNT)
            gain_r[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_gains(int pp, int pd, int rp, int rd, int yp, int yd);
        write_gain(REG_PITCH_P, GAIN_W'(pp));
        write_gain(REG_PITCH_D, GAIN_W'(pd));
        write_gain(REG_ROLL_P, GAIN_W'(rp));
        write_gain(REG_ROLL_D, GAIN_W'(rd));
        write_gain(REG_YAW_P, GAIN_W'(yp));
        write_gain(REG_YAW_D, GAIN_W'(yd));
    endtask

    // wait for all ticks answered, then let the datapath settle
    task automatic drain();
        while (ticks_taken != ticks_queued || motor_exp_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic random_phase(int count);
        int made;
        int len;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 15)
            begin
                push_tick(noise_tick());
                made++;
            end
            else
            begin
                flight_seq(len);
                made += len;
            end
        end
    endtask

    // stall lengths: mostly none or short, a few long
    function automatic int draw_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return pick(1, 3);
        else
            return pick(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // tick driver
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_fire))
        begin
            if (s_gap > 0)
            begin
                s_gap--;
                s_tvalid <= 1'b0;
            end
            else if (tick_q.size() > 0)
            begin
                s_tdata <= tick_q.pop_front();
                s_tvalid <= 1'b1;
                s_gap = draw_gap();
                if ($urandom_range(99) == 0)
                    calm = ~calm;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_gap > 0)
            begin
                m_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(99) < 25)
                    m_gap = draw_gap();
            end
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor: check results first, then predict newly accepted ticks
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        motor_out_t got;
        motor_out_t want;
        s_fire <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid === 1'b1 && m_tready)
            begin
                got = m_tdata;
                if (motor_exp_q.size() == 0)
                begin
                    $display("%0t: result with no tick pending, expected none, got %h",
                             $time, m_tdata);
                    err_cnt++;
                end
                else
                begin
                    want = motor_exp_q.pop_front();
                    check_field("motor_one", want.motor_one, got.motor_one);
                    check_field("motor_two", want.motor_two, got.motor_two);
                    check_field("motor_three", want.motor_three, got.motor_three);
                    check_field("motor_four", want.motor_four, got.motor_four);
                    check_field("flight_mode", want.flight_mode, got.flight_mode);
                    check_field("status_led", want.status_led, got.status_led);
                    check_field("heading_zero", want.heading_zero, got.heading_zero);
                end
            end
            if (s_tvalid && s_tready === 1'b1)
            begin
                motor_exp_q.push_back(predict_tick(s_tdata));
                ticks_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        gain_r[REG_PITCH_P] = GAIN_W'(P_GAIN_RST);
        gain_r[REG_PITCH_D] = GAIN_W'(D_GAIN_RST);
        gain_r[REG_ROLL_P] = GAIN_W'(P_GAIN_RST);
        gain_r[REG_ROLL_D] = GAIN_W'(D_GAIN_RST);
        gain_r[REG_YAW_P] = GAIN_W'(P_GAIN_RST);
        gain_r[REG_YAW_D] = GAIN_W'(D_GAIN_RST);
        mode_r = MODE_IDLE;
        blink_r = '0;
        led_r = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed corners, reset gains
        push_tick(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_tick(mk(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, RATE_MAX, RATE_MAX, RATE_MAX,
                     STICK_MAX, STICK_MAX, STICK_MAX, STICK_MAX));
        push_tick(mk(-ANGLE_MAX, -ANGLE_MAX, -ANGLE_MAX, -RATE_MAX, -RATE_MAX, -RATE_MAX,
                     -STICK_MAX, -STICK_MAX, -STICK_MAX, -STICK_MAX));
        // arming misses: throttle one above the limit, roll one below
        push_tick(mk(0, 0, 0, 0, 0, 0, STICK_LOW + 1, STICK_LOW, STICK_LOW, STICK_LOW));
        push_tick(mk(0, 0, 0, 0, 0, 0, STICK_LOW, STICK_LOW, STICK_LOW - 1, STICK_LOW));
        // arm exactly on the thresholds, hold at zero throttle, take off at one
        push_tick(mk(0, 0, 0, 0, 0, 0, STICK_LOW, STICK_LOW, STICK_LOW, STICK_LOW));
        push_tick(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_tick(mk(0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        // flying: zero throttle base, full and low throttle with saturated rates
        push_tick(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_tick(mk(4000, 4000, 0, RATE_MAX, RATE_MAX, RATE_MAX,
                     STICK_MAX, 0, 0, YAW_DEADBAND));
        push_tick(mk(-4000, -4000, 0, -RATE_MAX, -RATE_MAX, -RATE_MAX,
                     STICK_LOW + 1, 0, 0, -YAW_DEADBAND));
        // yaw stick just outside the deadband and at the ends
        push_tick(mk(100, -100, 3000, 500, -500, 700, 60, 10, -10, YAW_DEADBAND + 1));
        push_tick(mk(-100, 100, -3000, -500, 500, -700, 60, -10, 10, -YAW_DEADBAND - 1));
        push_tick(mk(0, 0, ANGLE_MAX, 0, 0, 0, 90, STICK_MAX, -STICK_MAX, STICK_MAX));
        push_tick(mk(0, 0, -ANGLE_MAX, 0, 0, 0, 90, -STICK_MAX, STICK_MAX, -STICK_MAX));
        // tilt exactly at 90 degrees stays airborne, one unit more crashes
        push_tick(mk(5760, -5760, 0, 0, 0, 0, 30, 0, 0, 0));
        push_tick(mk(5761, 0, 0, 0, 0, 0, 30, 0, 0, 0));
        // arm at the far corner of the pattern, take off at full throttle, land
        push_tick(mk(0, 0, 0, 0, 0, 0, -STICK_MAX, -STICK_MAX, STICK_MAX, -STICK_MAX));
        push_tick(mk(0, 0, 0, 0, 0, 0, STICK_MAX, 0, 0, 0));
        push_tick(mk(200, 200, 200, 200, 200, 200, STICK_LOW, 0, 0, 0));
        // pitch crash from below
        push_tick(mk(0, 0, 0, 0, 0, 0, STICK_LOW, STICK_LOW, STICK_LOW, STICK_LOW));
        push_tick(mk(0, 0, 0, 0, 0, 0, 20, 0, 0, 0));
        push_tick(mk(0, -5761, 0, 0, 0, 0, 20, 0, 0, 0));
        random_phase(PHASE_ITEMS);
        drain();

        // all gains at the top, spare index written too
        set_gains(255, 255, 255, 255, 255, 255);
        write_gain(REG_SPARE_6, GAIN_W'($urandom));
        random_phase(PHASE_ITEMS);
        drain();

        // all gains zero
        set_gains(0, 0, 0, 0, 0, 0);
        write_gain(REG_SPARE_7, GAIN_W'($urandom));
        random_phase(PHASE_ITEMS);
        drain();

        // random gains
        set_gains($urandom_range(255), $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), $urandom_range(255), $urandom_range(255));
        random_phase(PHASE_ITEMS);
        drain();

        // strong P, weak D, then back to reset values
        set_gains(255, 0, 255, 0, 255, 0);
        random_phase(PHASE_ITEMS / 2);
        drain();
        set_gains(P_GAIN_RST, D_GAIN_RST, P_GAIN_RST, D_GAIN_RST, P_GAIN_RST, D_GAIN_RST);
        random_phase(PHASE_ITEMS / 2);
        drain();

        repeat (20) @(negedge clk);
        if (err_cnt == 0)
            $display("quadcopter_attitude_pd_mixer_top_tb: clean");
        else
            $display("quadcopter_attitude_pd_mixer_top_tb: errors");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("quadcopter_attitude_pd_mixer_top_tb: errors");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/qapm_pkg.sv
hw/rtl/qapm_ctrl.sv
hw/rtl/qapm_datapath.sv
hw/rtl/quadcopter_attitude_pd_mixer_top.sv
hw/rtl/qapm_checker.sv
tb/sv/quadcopter_attitude_pd_mixer_top_tb.sv
